[hw/rtl/i2c_master_transaction_sequencer_unit_assert.svh]
// Assertion macros for the transaction sequencer
`ifndef I2C_MASTER_TRANSACTION_SEQUENCER_UNIT_ASSERT_SVH
`define I2C_MASTER_TRANSACTION_SEQUENCER_UNIT_ASSERT_SVH

// implication checked on every clock, off during reset
`define IMTS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define IMTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/imts_pkg.sv]
package imts_pkg;

   localparam int NumSlotsDefault = 16;
   localparam int MaxBytesDefault = 32;
   localparam logic [7:0] TimeoutReset = 8'd20;
   localparam int QueueDepth = 2;

   typedef enum logic [2:0] {
      OP_ADD    = 3'd0,
      OP_LOAD   = 3'd1,
      OP_READ   = 3'd2,
      OP_POST   = 3'd3,
      OP_STATUS = 3'd4,
      OP_TICK   = 3'd5,
      OP_QUERY  = 3'd6,
      OP_CLEAR  = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      CMD_NONE    = 3'd0,
      CMD_START   = 3'd1,
      CMD_SEND    = 3'd2,
      CMD_RX_ACK  = 3'd3,
      CMD_RX_NACK = 3'd4,
      CMD_STOP    = 3'd5,
      CMD_IDLE    = 3'd6
   } cmd_type;

   localparam logic [5:0] FL_TIMEOUT   = 6'h01;
   localparam logic [5:0] FL_PROG      = 6'h02;
   localparam logic [5:0] FL_WA_NACK   = 6'h04;
   localparam logic [5:0] FL_RA_NACK   = 6'h08;
   localparam logic [5:0] FL_DATA_NACK = 6'h10;
   localparam logic [5:0] FL_BUS       = 6'h20;

   localparam logic [7:0] ST_START     = 8'h08;
   localparam logic [7:0] ST_RESTART   = 8'h10;
   localparam logic [7:0] ST_WA_ACK    = 8'h18;
   localparam logic [7:0] ST_WA_NACK   = 8'h20;
   localparam logic [7:0] ST_WD_ACK    = 8'h28;
   localparam logic [7:0] ST_WD_NACK   = 8'h30;
   localparam logic [7:0] ST_ARB_LOST  = 8'h38;
   localparam logic [7:0] ST_RA_ACK    = 8'h40;
   localparam logic [7:0] ST_RA_NACK   = 8'h48;
   localparam logic [7:0] ST_RD_ACK    = 8'h50;
   localparam logic [7:0] ST_RD_NACK   = 8'h58;

   // decoded transaction handed from the front end to the back end
   typedef struct packed {
      op_type     op;
      logic [3:0] slot;
      logic [7:0] addr_byte;
      logic [5:0] length;
      logic [4:0] byte_index;
      logic [7:0] data;
      logic [7:0] status;
   } item_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_ADD_SCAN,
      ST_POST_SCAN,
      ST_CLEAR_SCAN,
      ST_ADV_SCAN,
      ST_RD_WAIT,
      ST_TX_WAIT,
      ST_RESPOND
   } seq_state_type;

endpackage

[hw/rtl/imts_front.sv]
module imts_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [2:0]          req_op,
   input  logic [3:0]          req_slot,
   input  logic [6:0]          req_target_address,
   input  logic                req_read_mode,
   input  logic [5:0]          req_length,
   input  logic [4:0]          req_byte_index,
   input  logic [7:0]          req_data,
   input  logic [7:0]          req_status,
   output logic                full,
   output logic                q_valid,
   output imts_pkg::item_type  q_item,
   input  logic                q_pop
);

   localparam int Depth = imts_pkg::QueueDepth;

   imts_pkg::item_type fifo_ff [Depth];
   logic                 rd_ptr_ff, rd_ptr_in;
   logic                 wr_ptr_ff, wr_ptr_in;
   logic [1:0]           count_ff, count_in;
   imts_pkg::item_type   item;
   logic                 push;

   // classify: form the address byte, mask status low bits
   always_comb begin
      item.op         = imts_pkg::op_type'(req_op);
      item.slot       = req_slot;
      item.addr_byte  = {req_target_address, req_read_mode};
      item.length     = req_length;
      item.byte_index = req_byte_index;
      item.data       = req_data;
      item.status     = {req_status[7:3], 3'b000};
   end

   assign push    = req_valid && !full;
   assign full    = (count_ff == 2'(Depth));
   assign q_valid = (count_ff != 2'd0);
   assign q_item  = fifo_ff[rd_ptr_ff];

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (q_pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      count_in = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= item;
      end
   end

   `include "i2c_master_transaction_sequencer_unit_assert.svh"

   `IMTS_ASSERT_IMP(a_no_pop_empty, clock, reset, q_pop, q_valid, "pop from empty queue")
   `IMTS_ASSERT_NEXT(a_count_push, clock, reset, push && !q_pop,
      count_ff == $past(count_ff) + 2'd1, "queue count lost a push")
   `IMTS_ASSERT_IMP(a_count_range, clock, reset, 1'b1, count_ff <= 2'(Depth),
      "queue overfilled")

endmodule

[hw/rtl/imts_back.sv]
module imts_back #(
   parameter int NUM_SLOTS = imts_pkg::NumSlotsDefault,
   parameter int MAX_BYTES = imts_pkg::MaxBytesDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [7:0]         timeout_ticks,
   input  logic               q_valid,
   input  imts_pkg::item_type q_item,
   output logic               q_pop,
   output logic               busy_back,
   output logic               rsp_valid,
   output logic [2:0]         rsp_command,
   output logic [7:0]         rsp_tx_byte,
   output logic [3:0]         rsp_result_slot,
   output logic               rsp_accepted,
   output logic [7:0]         rsp_read_byte,
   output logic               rsp_slot_done,
   output logic [5:0]         rsp_slot_flags,
   output logic               rsp_all_done,
   output logic               rsp_any_error
);

   localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int BW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
   localparam int AW = SW + BW;
   localparam int MemDepth = NUM_SLOTS * MAX_BYTES;

   // per-slot table in flip-flops
   logic [NUM_SLOTS-1:0] valid_ff, valid_in;
   logic [NUM_SLOTS-1:0] en_ff, en_in;
   logic [NUM_SLOTS-1:0] fin_ff, fin_in;
   logic [7:0]           addr_ff [NUM_SLOTS];
   logic [7:0]           addr_in [NUM_SLOTS];
   logic [5:0]           len_ff [NUM_SLOTS];
   logic [5:0]           len_in [NUM_SLOTS];
   logic [5:0]           err_ff [NUM_SLOTS];
   logic [5:0]           err_in [NUM_SLOTS];
   logic [5:0]           pos_ff [NUM_SLOTS];
   logic [5:0]           pos_in [NUM_SLOTS];
   logic [7:0]           tick_ff [NUM_SLOTS];
   logic [7:0]           tick_in [NUM_SLOTS];

   logic [SW-1:0] cur_ff, cur_in;
   logic          running_ff, running_in;
   logic          lfin_ff, lfin_in;
   logic          lerr_ff, lerr_in;

   imts_pkg::seq_state_type state_ff, state_in;
   imts_pkg::item_type      it_ff, it_in;
   logic [SW:0]             scan_ff, scan_in;
   logic                    any_ff, any_in;

   // result holding registers
   logic [2:0] cmd_ff, cmd_in;
   logic [7:0] tx_ff, tx_in;
   logic [4:0] rslot_ff, rslot_in;   // bit 4: out of range
   logic       acc_ff, acc_in;
   logic       rbsel_ff, rbsel_in;
   logic       txsel_ff, txsel_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // byte store
   logic [7:0]    mem [MemDepth];
   logic          mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [7:0]    mem_wdata, mem_rdata_ff;
   logic          mem_re;

   logic [SW-1:0] cs;
   logic          cur_usable;
   logic [5:0]    clen, cpos;
   logic [SW-1:0] scan_idx;
   logic          slot_ok;
   logic          idx_ok;
   logic [5:0]    sat_len;
   logic [SW-1:0] it_slot;
   logic [SW-1:0] rsel;

   function automatic logic [AW-1:0] mem_addr(input logic [SW-1:0] s, input logic [BW-1:0] b);
      logic [AW-1:0] a;
      a = AW'(s) * AW'(MAX_BYTES) + AW'(b);
      return a;
   endfunction

   assign cs       = cur_ff;
   assign clen     = len_ff[cs];
   assign cpos     = pos_ff[cs];
   assign cur_usable = valid_ff[cs] && (clen != 6'd0);
   assign scan_idx = scan_ff[SW-1:0];
   assign it_slot  = SW'(it_ff.slot);
   assign slot_ok  = ({3'b000, it_ff.slot} < 7'(NUM_SLOTS));
   assign idx_ok   = ({4'b0000, it_ff.byte_index} < 9'(MAX_BYTES));
   assign sat_len  = (32'(it_ff.length) > 32'(MAX_BYTES)) ? 6'(MAX_BYTES) : it_ff.length;
   assign q_pop    = (state_ff == imts_pkg::ST_IDLE) && q_valid;
   assign busy_back = (state_ff != imts_pkg::ST_IDLE);

   always_comb begin
      state_in   = state_ff;
      it_in      = it_ff;
      scan_in    = scan_ff;
      any_in     = any_ff;
      valid_in   = valid_ff;
      en_in      = en_ff;
      fin_in     = fin_ff;
      addr_in    = addr_ff;
      len_in     = len_ff;
      err_in     = err_ff;
      pos_in     = pos_ff;
      tick_in    = tick_ff;
      cur_in     = cur_ff;
      running_in = running_ff;
      lfin_in    = lfin_ff;
      lerr_in    = lerr_ff;
      cmd_in     = cmd_ff;
      tx_in      = tx_ff;
      rslot_in   = rslot_ff;
      acc_in     = acc_ff;
      rbsel_in   = rbsel_ff;
      txsel_in   = txsel_ff;
      rsp_valid_in = 1'b0;
      mem_we     = 1'b0;
      mem_waddr  = mem_addr(cs, BW'(cpos));
      mem_wdata  = it_ff.data;
      mem_re     = 1'b0;
      mem_raddr  = mem_addr(cs, BW'(cpos));

      unique case (state_ff)
         imts_pkg::ST_IDLE: begin
            if (q_valid) begin
               it_in    = q_item;
               state_in = imts_pkg::ST_DECODE;
            end
         end
         imts_pkg::ST_DECODE: begin
            cmd_in   = imts_pkg::CMD_NONE;
            tx_in    = 8'd0;
            rslot_in = {1'b0, 4'(cur_ff)};
            acc_in   = 1'b0;
            rbsel_in = 1'b0;
            txsel_in = 1'b0;
            scan_in  = '0;
            any_in   = 1'b0;
            state_in = imts_pkg::ST_RESPOND;
            unique case (it_ff.op)
               imts_pkg::OP_ADD:   state_in = imts_pkg::ST_ADD_SCAN;
               imts_pkg::OP_POST:  state_in = imts_pkg::ST_POST_SCAN;
               imts_pkg::OP_CLEAR: state_in = imts_pkg::ST_CLEAR_SCAN;
               imts_pkg::OP_LOAD: begin
                  if (slot_ok && idx_ok) begin
                     mem_we    = 1'b1;
                     mem_waddr = mem_addr(it_slot, BW'(it_ff.byte_index));
                  end
               end
               imts_pkg::OP_READ: begin
                  if (slot_ok && idx_ok) begin
                     mem_re    = 1'b1;
                     mem_raddr = mem_addr(it_slot, BW'(it_ff.byte_index));
                     rbsel_in  = 1'b1;
                     state_in  = imts_pkg::ST_RD_WAIT;
                  end
               end
               imts_pkg::OP_QUERY: begin
                  rslot_in = slot_ok ? {1'b0, it_ff.slot} : 5'h10;
                  acc_in   = slot_ok && valid_ff[it_slot] && (len_ff[it_slot] != 6'd0);
               end
               imts_pkg::OP_TICK: begin
                  if (cur_usable && running_ff && en_ff[cs] && !fin_ff[cs]) begin
                     if (tick_ff[cs] == 8'd0) begin
                        err_in[cs] = err_ff[cs] | imts_pkg::FL_TIMEOUT;
                        fin_in[cs] = 1'b1;
                     end else begin
                        tick_in[cs] = tick_ff[cs] - 8'd1;
                     end
                  end
               end
               imts_pkg::OP_STATUS: begin
                  if (!running_ff || lfin_ff) begin
                     cmd_in = imts_pkg::CMD_STOP;
                  end else if (!cur_usable) begin
                     lfin_in    = 1'b1;
                     running_in = 1'b0;
                     lerr_in    = 1'b1;
                     scan_in    = (SW+1)'(cur_ff) + 1'b1;
                     state_in   = imts_pkg::ST_ADV_SCAN;
                  end else if (!en_ff[cs] || fin_ff[cs]) begin
                     fin_in[cs] = 1'b1;
                     en_in[cs]  = 1'b0;
                     err_in[cs] = err_ff[cs] | imts_pkg::FL_PROG;
                     lerr_in    = 1'b1;
                     scan_in    = (SW+1)'(cur_ff) + 1'b1;
                     state_in   = imts_pkg::ST_ADV_SCAN;
                  end else begin
                     priority case (it_ff.status)
                        imts_pkg::ST_START, imts_pkg::ST_RESTART: begin
                           pos_in[cs] = 6'd0;
                           tx_in      = addr_ff[cs];
                           cmd_in     = imts_pkg::CMD_SEND;
                        end
                        imts_pkg::ST_WA_ACK, imts_pkg::ST_WD_ACK: begin
                           if (cpos < clen) begin
                              mem_re     = 1'b1;
                              txsel_in   = 1'b1;
                              pos_in[cs] = cpos + 6'd1;
                              cmd_in     = imts_pkg::CMD_SEND;
                              state_in   = imts_pkg::ST_TX_WAIT;
                           end else begin
                              fin_in[cs] = 1'b1;
                              en_in[cs]  = 1'b0;
                              scan_in    = (SW+1)'(cur_ff) + 1'b1;
                              state_in   = imts_pkg::ST_ADV_SCAN;
                           end
                        end
                        imts_pkg::ST_RD_ACK: begin
                           if (cpos < clen) begin
                              mem_we     = 1'b1;
                              pos_in[cs] = cpos + 6'd1;
                              cmd_in = (7'(cpos) + 7'd2 < 7'(clen)) ?
                                 imts_pkg::CMD_RX_ACK : imts_pkg::CMD_RX_NACK;
                           end else begin
                              cmd_in = (7'(cpos) + 7'd1 < 7'(clen)) ?
                                 imts_pkg::CMD_RX_ACK : imts_pkg::CMD_RX_NACK;
                           end
                        end
                        imts_pkg::ST_RA_ACK: begin
                           cmd_in = (7'(cpos) + 7'd1 < 7'(clen)) ?
                              imts_pkg::CMD_RX_ACK : imts_pkg::CMD_RX_NACK;
                        end
                        imts_pkg::ST_RD_NACK: begin
                           if (cpos < clen) begin
                              mem_we = 1'b1;
                           end
                           fin_in[cs] = 1'b1;
                           en_in[cs]  = 1'b0;
                           scan_in    = (SW+1)'(cur_ff) + 1'b1;
                           state_in   = imts_pkg::ST_ADV_SCAN;
                        end
                        imts_pkg::ST_ARB_LOST: cmd_in = imts_pkg::CMD_START;
                        default: begin
                           fin_in[cs] = 1'b1;
                           en_in[cs]  = 1'b0;
                           lerr_in    = 1'b1;
                           if (it_ff.status == imts_pkg::ST_WA_NACK) begin
                              err_in[cs] = err_ff[cs] | imts_pkg::FL_WA_NACK;
                           end else if (it_ff.status == imts_pkg::ST_RA_NACK) begin
                              err_in[cs] = err_ff[cs] | imts_pkg::FL_RA_NACK;
                           end else if (it_ff.status == imts_pkg::ST_WD_NACK) begin
                              err_in[cs] = err_ff[cs] | imts_pkg::FL_DATA_NACK;
                           end else begin
                              err_in[cs] = err_ff[cs] | imts_pkg::FL_BUS;
                           end
                           scan_in  = (SW+1)'(cur_ff) + 1'b1;
                           state_in = imts_pkg::ST_ADV_SCAN;
                        end
                     endcase
                  end
               end
               default: ;
            endcase
         end
         // first free slot, one slot a cycle
         imts_pkg::ST_ADD_SCAN: begin
            if (scan_ff == (SW+1)'(NUM_SLOTS)) begin
               state_in = imts_pkg::ST_RESPOND;
            end else if (!valid_ff[scan_idx]) begin
               valid_in[scan_idx] = 1'b1;
               en_in[scan_idx]    = 1'b0;
               fin_in[scan_idx]   = 1'b0;
               err_in[scan_idx]   = 6'd0;
               pos_in[scan_idx]   = 6'd0;
               addr_in[scan_idx]  = it_ff.addr_byte;
               len_in[scan_idx]   = sat_len;
               tick_in[scan_idx]  = timeout_ticks;
               rslot_in = 5'(scan_idx);
               acc_in   = 1'b1;
               state_in = imts_pkg::ST_RESPOND;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         imts_pkg::ST_POST_SCAN: begin
            if (scan_ff == (SW+1)'(NUM_SLOTS)) begin
               cur_in   = '0;
               lerr_in  = 1'b0;
               rslot_in = 5'd0;
               if (any_ff) begin
                  lfin_in    = 1'b0;
                  running_in = 1'b1;
                  cmd_in     = imts_pkg::CMD_START;
               end else begin
                  lfin_in    = 1'b1;
                  running_in = 1'b0;
                  cmd_in     = imts_pkg::CMD_IDLE;
               end
               state_in = imts_pkg::ST_RESPOND;
            end else begin
               if (valid_ff[scan_idx] && len_ff[scan_idx] != 6'd0) begin
                  en_in[scan_idx]   = 1'b1;
                  fin_in[scan_idx]  = 1'b0;
                  err_in[scan_idx]  = 6'd0;
                  tick_in[scan_idx] = timeout_ticks;
                  pos_in[scan_idx]  = 6'd0;
                  any_in = 1'b1;
               end
               scan_in = scan_ff + 1'b1;
            end
         end
         imts_pkg::ST_CLEAR_SCAN: begin
            if (scan_ff == (SW+1)'(NUM_SLOTS)) begin
               cur_in     = '0;
               running_in = 1'b0;
               lfin_in    = 1'b0;
               lerr_in    = 1'b0;
               rslot_in   = 5'd0;
               state_in   = imts_pkg::ST_RESPOND;
            end else begin
               valid_in[scan_idx] = 1'b0;
               en_in[scan_idx]    = 1'b0;
               fin_in[scan_idx]   = 1'b0;
               addr_in[scan_idx]  = 8'd0;
               len_in[scan_idx]   = 6'd0;
               err_in[scan_idx]   = 6'd0;
               pos_in[scan_idx]   = 6'd0;
               tick_in[scan_idx]  = 8'd0;
               scan_in = scan_ff + 1'b1;
            end
         end
         // next enabled, unfinished transfer, or end of list
         imts_pkg::ST_ADV_SCAN: begin
            if (scan_ff >= (SW+1)'(NUM_SLOTS)) begin
               lfin_in    = 1'b1;
               running_in = 1'b0;
               cmd_in     = imts_pkg::CMD_STOP;
               rslot_in   = {1'b0, 4'(cur_ff)};
               state_in   = imts_pkg::ST_RESPOND;
            end else begin
               cur_in = scan_idx;
               if (valid_ff[scan_idx] && len_ff[scan_idx] != 6'd0 &&
                   en_ff[scan_idx] && !fin_ff[scan_idx]) begin
                  cmd_in   = imts_pkg::CMD_START;
                  rslot_in = 5'(scan_idx);
                  state_in = imts_pkg::ST_RESPOND;
               end else begin
                  scan_in = scan_ff + 1'b1;
               end
            end
         end
         imts_pkg::ST_RD_WAIT: state_in = imts_pkg::ST_RESPOND;
         // tx byte from the store once the read returns
         imts_pkg::ST_TX_WAIT: begin
            tx_in    = mem_rdata_ff;
            rslot_in = {1'b0, 4'(cur_ff)};
            state_in = imts_pkg::ST_RESPOND;
         end
         imts_pkg::ST_RESPOND: begin
            if (it_ff.op == imts_pkg::OP_STATUS || it_ff.op == imts_pkg::OP_TICK) begin
               rslot_in = {1'b0, 4'(cur_ff)};
            end
            rsp_valid_in = 1'b1;
            state_in     = imts_pkg::ST_IDLE;
         end
         default: state_in = imts_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= imts_pkg::ST_IDLE;
         valid_ff     <= '0;
         en_ff        <= '0;
         fin_ff       <= '0;
         cur_ff       <= '0;
         running_ff   <= 1'b0;
         lfin_ff      <= 1'b0;
         lerr_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            addr_ff[i] <= 8'd0;
            len_ff[i]  <= 6'd0;
            err_ff[i]  <= 6'd0;
            pos_ff[i]  <= 6'd0;
            tick_ff[i] <= 8'd0;
         end
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         en_ff        <= en_in;
         fin_ff       <= fin_in;
         cur_ff       <= cur_in;
         running_ff   <= running_in;
         lfin_ff      <= lfin_in;
         lerr_ff      <= lerr_in;
         rsp_valid_ff <= rsp_valid_in;
         addr_ff      <= addr_in;
         len_ff       <= len_in;
         err_ff       <= err_in;
         pos_ff       <= pos_in;
         tick_ff      <= tick_in;
      end
   end

   always_ff @(posedge clock) begin
      it_ff    <= it_in;
      scan_ff  <= scan_in;
      any_ff   <= any_in;
      cmd_ff   <= cmd_in;
      tx_ff    <= tx_in;
      rslot_ff <= rslot_in;
      acc_ff   <= acc_in;
      rbsel_ff <= rbsel_in;
      txsel_ff <= txsel_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= mem[mem_raddr];
      end
   end

   assign rsel = rslot_ff[SW-1:0];

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_command     = cmd_ff;
   assign rsp_tx_byte     = tx_ff;
   assign rsp_result_slot = rslot_ff[3:0];
   assign rsp_accepted    = acc_ff;
   assign rsp_read_byte   = rbsel_ff ? mem_rdata_ff : 8'd0;
   assign rsp_slot_done   = rslot_ff[4] ? 1'b0 : fin_ff[rsel];
   assign rsp_slot_flags  = rslot_ff[4] ? 6'd0 : err_ff[rsel];
   assign rsp_all_done    = lfin_ff;
   assign rsp_any_error   = lerr_ff;

   `include "i2c_master_transaction_sequencer_unit_assert.svh"

   `IMTS_ASSERT_NEXT(a_rsp_after_respond, clock, reset,
      state_ff == imts_pkg::ST_RESPOND, rsp_valid, "response missed")
   `IMTS_ASSERT_IMP(a_pop_idle, clock, reset, q_pop,
      state_ff == imts_pkg::ST_IDLE, "pop while busy")
   `IMTS_ASSERT_IMP(a_run_fin, clock, reset, running_ff, !lfin_ff,
      "list running and finished at once")

endmodule

[hw/rtl/i2c_master_transaction_sequencer_unit.sv]
// channel     | ports                     | handshake
// request     | start, busy, req_*        | taken when start && !busy
// response    | rsp_valid, rsp_*          | one-cycle strobe, no backpressure
// csr         | csr_valid, csr_ready, csr_*| written when valid && ready
//
// A transaction passes through the queue and the back end's decode and respond
// states; a read or a data send also waits for the byte store, and add, post,
// clear and list advance scan the slots in the back end, one slot a cycle.
// busy rises while the two-entry queue between front and back is full.
// Reset is synchronous; it empties the table and the queue. The byte store
// is not cleared and reads undefined until written.
module i2c_master_transaction_sequencer_unit #(
   parameter int NUM_SLOTS = imts_pkg::NumSlotsDefault,
   parameter int MAX_BYTES = imts_pkg::MaxBytesDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [2:0] req_op,
   input  logic [3:0] req_slot,
   input  logic [6:0] req_target_address,
   input  logic       req_read_mode,
   input  logic [5:0] req_length,
   input  logic [4:0] req_byte_index,
   input  logic [7:0] req_data,
   input  logic [7:0] req_status,
   output logic       rsp_valid,
   output logic [2:0] rsp_command,
   output logic [7:0] rsp_tx_byte,
   output logic [3:0] rsp_result_slot,
   output logic       rsp_accepted,
   output logic [7:0] rsp_read_byte,
   output logic       rsp_slot_done,
   output logic [5:0] rsp_slot_flags,
   output logic       rsp_all_done,
   output logic       rsp_any_error,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_timeout_ticks
);

   logic               full;
   logic               q_valid;
   logic               q_pop;
   logic               busy_back;
   imts_pkg::item_type q_item;
   logic [7:0]         timeout_ff;

   assign busy      = full;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= imts_pkg::TimeoutReset;
      end else if (csr_valid && csr_ready) begin
         timeout_ff <= csr_timeout_ticks;
      end
   end

   imts_front u_front (
      .clock,
      .reset,
      .req_valid(start),
      .req_op,
      .req_slot,
      .req_target_address,
      .req_read_mode,
      .req_length,
      .req_byte_index,
      .req_data,
      .req_status,
      .full,
      .q_valid,
      .q_item,
      .q_pop
   );

   imts_back #(.NUM_SLOTS(NUM_SLOTS), .MAX_BYTES(MAX_BYTES)) u_back (
      .clock,
      .reset,
      .timeout_ticks(timeout_ff),
      .q_valid,
      .q_item,
      .q_pop,
      .busy_back,
      .rsp_valid,
      .rsp_command,
      .rsp_tx_byte,
      .rsp_result_slot,
      .rsp_accepted,
      .rsp_read_byte,
      .rsp_slot_done,
      .rsp_slot_flags,
      .rsp_all_done,
      .rsp_any_error
   );

   `include "i2c_master_transaction_sequencer_unit_assert.svh"

   `IMTS_ASSERT_IMP(a_busy_full, clock, reset, busy && !busy_back, q_pop,
      "full queue not drained by idle back end")

endmodule
